// File: src/xbr_pkg.sv
`default_nettype none

package xbr_pkg;

  // Field and datapath widths
  localparam int unsigned BOUND_W  = 31;
  localparam int unsigned VALUE_W  = 31;
  localparam int unsigned GEN_W    = 64;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(SAMPLE_W);

  typedef logic [BOUND_W-1:0]  bound_t;
  typedef logic [VALUE_W-1:0]  value_t;
  typedef logic [GEN_W-1:0]    gen_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  // xorshift64* constants
  localparam gen_t XS_MULT      = 64'h2545_F491_4F6C_DD1D;
  localparam int unsigned XS_SHIFT_A = 12;
  localparam int unsigned XS_SHIFT_B = 25;
  localparam int unsigned XS_SHIFT_C = 27;
  localparam gen_t SEED_RESET   = 64'd1;

  // 2^32 as a 33-bit value, for the rejection test
  localparam logic [SAMPLE_W:0] SPAN = {1'b1, {SAMPLE_W{1'b0}}};

endpackage

`default_nettype wire

// File: src/xbr_if.sv
`default_nettype none

interface xbr_req_if import xbr_pkg::*; ();
  logic   valid;
  logic   ready;
  bound_t bound;

  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

interface xbr_rsp_if import xbr_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: src/xorshift_bounded_random.sv
`default_nettype none

// Bounded uniform random source on a 64-bit xorshift64* generator. Each request
// carries an exclusive bound n and returns one value, uniform in 0..n-1. A bound
// of 0 or 1 answers 0 through the done state without a draw and leaves the
// generator alone. Otherwise each draw runs a shift/xor update, then the MA to MD
// steps on a single shared 32x32 multiplier that build bits 63..32 of the
// product, a one-bit-per-cycle restoring divider that yields the remainder, and
// the rejection check; a rejected draw repeats all of these steps. Fewer than
// half of all draws are rejected, so most requests need a single draw. One
// request is in flight at a time; the next can be taken while the result
// waits on out_rsp. Writing cfg_wdata with cfg_we loads the seed into the
// generator at once; do so only while no request is in flight. A zero seed
// makes every answer 0.
module xorshift_bounded_random import xbr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire gen_t       cfg_wdata,
  xbr_req_if.sink         in_req,
  xbr_rsp_if.source       out_rsp
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_XS   = 4'd1;
  localparam logic [3:0] ST_MA   = 4'd2;
  localparam logic [3:0] ST_MB   = 4'd3;
  localparam logic [3:0] ST_MC   = 4'd4;
  localparam logic [3:0] ST_MD   = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_CHK  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SAMPLE_W - 1);

  logic [3:0]            st_r, st_nxt;
  gen_t                  gen_r, gen_nxt;
  bound_t                bound_r, bound_nxt;
  logic [2*SAMPLE_W-1:0] prod_r, prod_nxt;
  sample_t               acc_r, acc_nxt;
  sample_t               samp_r, samp_nxt;
  sample_t               div_r, div_nxt;
  value_t                rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  value_t                out_value_r, out_value_nxt;

  logic                  in_acc;
  logic                  out_free;
  gen_t                  xs1, xs2, xs3;
  sample_t               mul_a, mul_b;
  logic [2*SAMPLE_W-1:0] mul_p;
  sample_t               rem_sh;
  logic [SAMPLE_W:0]     div_diff;
  logic [SAMPLE_W:0]     chk_sum;
  logic                  reject;

  assign in_req.ready  = (st_r == ST_IDLE);
  assign in_acc        = in_req.valid && in_req.ready;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.value = out_value_r;
  assign out_free      = !out_valid_r || out_rsp.ready;

  // Generator update: three shift/xor passes
  always_comb begin
    xs1 = gen_r ^ (gen_r >> XS_SHIFT_A);
    xs2 = xs1 ^ (xs1 << XS_SHIFT_B);
    xs3 = xs2 ^ (xs2 >> XS_SHIFT_C);
  end

  // Shared multiplier: pick the partial product for this phase
  always_comb begin
    unique case (st_r)
      ST_MA: begin
        mul_a = gen_r[SAMPLE_W-1:0];
        mul_b = XS_MULT[SAMPLE_W-1:0];
      end
      ST_MB: begin
        mul_a = gen_r[SAMPLE_W-1:0];
        mul_b = XS_MULT[GEN_W-1:SAMPLE_W];
      end
      ST_MC: begin
        mul_a = gen_r[GEN_W-1:SAMPLE_W];
        mul_b = XS_MULT[SAMPLE_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider step: shift in one dividend bit, subtract when it fits
  assign rem_sh   = {rem_r, div_r[SAMPLE_W-1]};
  assign div_diff = {1'b0, rem_sh} - {2'b00, bound_r};

  // Reject when the quotient's multiple plus n passes 2^32
  assign chk_sum = {1'b0, samp_r - {1'b0, rem_r}} + {2'b00, bound_r};
  assign reject  = chk_sum > SPAN;

  // Sequencer and datapath
  always_comb begin
    st_nxt        = st_r;
    gen_nxt       = gen_r;
    bound_nxt     = bound_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    samp_nxt      = samp_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;

    // drop the result once taken
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          bound_nxt = in_req.bound;
          if (in_req.bound <= bound_t'(1)) begin
            rem_nxt = '0;
            st_nxt  = ST_DONE;
          end else begin
            st_nxt  = ST_XS;
          end
        end
      end
      ST_XS: begin
        gen_nxt = xs3;
        st_nxt  = ST_MA;
      end
      ST_MA: begin
        prod_nxt = mul_p;
        st_nxt   = ST_MB;
      end
      ST_MB: begin
        acc_nxt  = prod_r[2*SAMPLE_W-1:SAMPLE_W];
        prod_nxt = mul_p;
        st_nxt   = ST_MC;
      end
      ST_MC: begin
        acc_nxt  = acc_r + prod_r[SAMPLE_W-1:0];
        prod_nxt = mul_p;
        st_nxt   = ST_MD;
      end
      ST_MD: begin
        samp_nxt = acc_r + prod_r[SAMPLE_W-1:0];
        div_nxt  = acc_r + prod_r[SAMPLE_W-1:0];
        rem_nxt  = '0;
        cnt_nxt  = '0;
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = div_diff[SAMPLE_W] ? rem_sh[VALUE_W-1:0] : div_diff[VALUE_W-1:0];
        div_nxt = {div_r[SAMPLE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          st_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        st_nxt = reject ? ST_XS : ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rem_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // seed write reloads the generator
    if (cfg_we) begin
      gen_nxt = cfg_wdata;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      gen_r       <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    bound_r     <= bound_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    samp_r      <= samp_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_value_r <= out_value_nxt;
  end

  // Remainder stays below the bound throughout the division
  a_rem_lt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (rem_r < bound_r))
    else $error("divider remainder reached the bound");

  // Trivial bound leaves the generator untouched
  a_trivial_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_req.bound <= bound_t'(1)) && !cfg_we) |=> $stable(gen_r))
    else $error("generator advanced on a trivial bound");

  // Check follows a full division pass
  a_chk_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHK) |-> ($past(st_r) == ST_DIV && $past(cnt_r) == DIV_LAST))
    else $error("rejection check without a full division");

  // Finished request reaches the output once it is free
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && out_free) |=> (out_valid_r && st_r == ST_IDLE))
    else $error("result not posted");

endmodule

`default_nettype wire

// File: tb/xorshift_bounded_random_test.sv
`default_nettype none

module xorshift_bounded_random_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xbr_pkg::*;

  // One outstanding request: the bound sent and the value it must return
  typedef struct packed {
    bound_t bound;
    value_t value;
  } draw_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  gen_t cfg_wdata;

  xbr_req_if in_req ();
  xbr_rsp_if out_rsp ();

  xorshift_bounded_random dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  gen_t  gen_state;
  draw_t pending_draws[$];
  int    mismatches;
  int    requests_sent;
  int    results_seen;
  int    seed_loads;
  int    trivial_count;
  int    pow2_count;
  bit    calm;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #25ms;
    $display("Timeout: %0d requests still unanswered", pending_draws.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One xorshift64* state step
  function automatic gen_t xorshift_step(gen_t s);
    s = s ^ (s >> XS_SHIFT_A);
    s = s ^ (s << XS_SHIFT_B);
    s = s ^ (s >> XS_SHIFT_C);
    return s;
  endfunction

  // Draw until a sample falls below the largest multiple of n, then reduce
  function automatic value_t bounded_draw(bound_t n);
    logic [63:0] span;
    logic [63:0] limit;
    logic [63:0] product;
    logic [63:0] sample;
    if (n <= 1) return '0;
    span  = 64'd1 << 32;
    limit = span - (span % n);
    do begin
      gen_state = xorshift_step(gen_state);
      product   = gen_state * XS_MULT;
      sample    = product >> 32;
    end while (sample >= limit);
    return value_t'(sample % n);
  endfunction

  // Mix of trivial, small, power-of-two, high-rejection and full-width bounds
  function automatic bound_t random_bound();
    case ($urandom_range(0, 9))
      0:       return bound_t'($urandom_range(0, 1));
      1, 2:    return bound_t'($urandom_range(2, 20));
      3:       return bound_t'(32'd1 << $urandom_range(1, 30));
      4:       return bound_t'($urandom_range(32'h5555_5556, 32'h6000_0000));
      5:       return bound_t'($urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF));
      default: return bound_t'($urandom());
    endcase
  endfunction

  // Send one request; predict its value once it is taken
  task automatic send_request(bound_t b);
    int    gap;
    draw_t d;
    gap = pick_gap();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.bound <= b;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    d.bound = b;
    d.value = bounded_draw(b);
    pending_draws.push_back(d);
    requests_sent++;
    if (b <= 1) trivial_count++;
    else if ((b & (b - 1)) == 0) pow2_count++;
  endtask

  // Hold off requests until every answer is back
  task automatic wait_idle();
    in_req.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Load a new seed into the generator
  task automatic load_seed(gen_t s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_state = s;
    seed_loads++;
  endtask

  // Response side: random back-pressure, steady in calm stretches
  initial begin
    int hold;
    hold = 0;
    out_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm) begin
        out_rsp.ready <= 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        out_rsp.ready <= 1'b0;
        hold = pick_gap();
      end else begin
        out_rsp.ready <= 1'b1;
        hold = $urandom_range(0, 4);
      end
    end
  end

  // Compare each answer against the oldest prediction
  initial begin
    draw_t d;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
        results_seen++;
        if (pending_draws.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected answer %0d with no request pending", out_rsp.value);
        end else begin
          d = pending_draws.pop_front();
          if (out_rsp.value !== d.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Value mismatch for bound %0d: expected %0d, got %0d",
                       d.bound, d.value, out_rsp.value);
          end
        end
      end
    end
  end

  // Corner bounds straight out of reset, seed still at its reset value
  task automatic test_reset_seed();
    bound_t corner_bounds[] = '{31'd0, 31'd1, 31'd2, 31'd3, 31'h7FFF_FFFF,
                                31'h4000_0000, 31'h7FFF_FFFE, 31'h5555_5556,
                                31'd1, 31'd0, 31'd16, 31'd100};
    foreach (corner_bounds[i]) send_request(corner_bounds[i]);
  endtask

  // Zero seed, all-ones seed and a reload of one
  task automatic test_seed_extremes();
    wait_idle();
    load_seed(64'd0);
    send_request(31'h7FFF_FFFF);
    send_request(31'd2);
    send_request(31'd1000);
    send_request(31'd1);
    wait_idle();
    load_seed({64{1'b1}});
    send_request(31'h7FFF_FFFF);
    send_request(31'h5555_5556);
    send_request(31'd3);
    send_request(31'd0);
    wait_idle();
    load_seed(64'd1);
    send_request(31'h4000_0000);
    send_request(31'h2AAA_AAAB);
    send_request(31'd6);
  endtask

  // Random bound streams under several seeds, with a full drain mid-stream
  task automatic test_random_streams();
    gen_t seeds[5];
    seeds[0] = {$urandom(), $urandom()};
    seeds[1] = 64'h8000_0000_0000_0000;
    seeds[2] = {$urandom(), $urandom()};
    seeds[3] = {32'd0, $urandom()};
    seeds[4] = {$urandom(), $urandom()};
    foreach (seeds[p]) begin
      wait_idle();
      load_seed(seeds[p]);
      for (int i = 0; i < 170; i++) begin
        if (i % 40 == 0) calm <= ($urandom_range(0, 3) == 0);
        if (i == 90) wait_idle();
        send_request(random_bound());
      end
    end
    calm <= 1'b0;
  endtask

  // Reset, run each test in turn, then drain and report
  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_req.valid <= 1'b0;
    in_req.bound <= '0;
    calm         = 1'b0;
    gen_state    = SEED_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_seed();
    test_seed_extremes();
    test_random_streams();

    in_req.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending_draws.size() != 0) begin
      mismatches += pending_draws.size();
      $display("%0d requests never answered", pending_draws.size());
    end
    $display("Covered %0d requests (%0d answered) across %0d seed loads",
             requests_sent, results_seen, seed_loads);
    $display("Included %0d trivial bounds and %0d power-of-two bounds, %0d mismatches",
             trivial_count, pow2_count, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
